[hw/rtl/tlc_pkg.sv]
// Shared types and constants for the timestamp LRU tag cache.
`timescale 1ns / 1ps

package tlc_pkg;

    localparam int KEY_ID_W    = 16;
    localparam int KEY_COUNT_W = 31;
    localparam int HANDLE_W    = 32;
    localparam int AGE_W       = 32;
    localparam int SLOT_W      = 8;

    // Request opcodes
    typedef enum logic [1:0] {
        OP_LOOKUP = 2'd0,
        OP_FILL   = 2'd1,
        OP_TICK   = 2'd2,
        OP_CLEAR  = 2'd3
    } op_t;

    // Search token that walks down the cell chain, one cell per cycle.
    // sel_* holds the matched entry on a lookup and the current victim on a fill.
    typedef struct packed {
        logic                   live;
        op_t                    op;
        logic                   done;
        logic                   sel_valid;
        logic [KEY_ID_W-1:0]    key_id;
        logic [KEY_COUNT_W-1:0] key_count;
        logic [HANDLE_W-1:0]    handle;
        logic [HANDLE_W-1:0]    sel_payload;
        logic [AGE_W-1:0]       best_age;
    } token_t;

    // Controls broadcast from the top level to every cell
    typedef struct packed {
        logic                   clear;
        logic                   wr_en;
        logic [AGE_W-1:0]       frame;
        logic [KEY_ID_W-1:0]    key_id;
        logic [KEY_COUNT_W-1:0] key_count;
        logic [HANDLE_W-1:0]    handle;
    } bcast_t;

endpackage

[hw/rtl/timestamp_lru_tag_cache.sv]
// Top level of the fully associative tag cache with timestamp LRU replacement.
//
//  Channel | Handshake            | Fields
//  --------+----------------------+------------------------------------------------
//  request | req_valid/req_stall  | op, key_id, key_count, fill_handle
//  result  | rsp_valid/rsp_stall  | hit, found_handle, slot_index, evicted,
//          |                      | evicted_handle
//
// A lookup or fill sends a search token down the row of ENTRIES cells, one cell
// per cycle; the next request is taken once its result has been delivered.
// A frame tick or a clear launches no token; the clear resets all entries at once.
// One request is handled at a time; a result waiting under rsp_stall holds the
// block once the following request has finished. Reset empties the cache and
// zeroes the frame counter immediately.
`timescale 1ns / 1ps

module timestamp_lru_tag_cache #(
    parameter int ENTRIES = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_stall,
    input  logic [1:0]  op,
    input  logic [15:0] key_id,
    input  logic [30:0] key_count,
    input  logic [31:0] fill_handle,
    output logic        rsp_valid,
    input  logic        rsp_stall,
    output logic        hit,
    output logic [31:0] found_handle,
    output logic [7:0]  slot_index,
    output logic        evicted,
    output logic [31:0] evicted_handle
);

    localparam int IDX_W  = $clog2(ENTRIES);
    localparam int SLOT_W = tlc_pkg::SLOT_W;

    typedef enum logic [2:0] {
        ST_IDLE    = 3'b001,
        ST_SCAN    = 3'b010,
        ST_DELIVER = 3'b100
    } state_t;

    state_t state_reg, state_next;

    tlc_pkg::token_t           launch_reg, launch_next;
    logic [tlc_pkg::AGE_W-1:0] frame_reg, frame_next;

    logic                         res_hit_reg, res_hit_next;
    logic [tlc_pkg::HANDLE_W-1:0] res_found_reg, res_found_next;
    logic [SLOT_W-1:0]            res_slot_reg, res_slot_next;
    logic                         res_ev_reg, res_ev_next;
    logic [tlc_pkg::HANDLE_W-1:0] res_evh_reg, res_evh_next;

    logic                         rsp_valid_reg, rsp_valid_next;
    logic                         hit_reg, hit_next;
    logic [tlc_pkg::HANDLE_W-1:0] found_reg, found_next;
    logic [SLOT_W-1:0]            slot_reg, slot_next;
    logic                         ev_reg, ev_next;
    logic [tlc_pkg::HANDLE_W-1:0] evh_reg, evh_next;

    tlc_pkg::token_t  tok_w [0:ENTRIES];
    logic [IDX_W-1:0] idx_w [0:ENTRIES];

    tlc_pkg::bcast_t  bcast;
    tlc_pkg::token_t  tok_end;
    logic [IDX_W-1:0] idx_end;
    logic [SLOT_W-1:0] end_slot;
    tlc_pkg::op_t     req_op;
    logic             req_xfer;

    assign req_op    = tlc_pkg::op_t'(op);
    assign req_stall = (state_reg != ST_IDLE);
    assign req_xfer  = req_valid && !req_stall;

    assign tok_end = tok_w[ENTRIES];
    assign idx_end = idx_w[ENTRIES];

    // Low bits of the entry index form the reported slot
    if (IDX_W >= SLOT_W)
    begin : g_slot_trunc
        assign end_slot = idx_end[SLOT_W-1:0];
    end
    else
    begin : g_slot_ext
        assign end_slot = {{(SLOT_W-IDX_W){1'b0}}, idx_end};
    end

    // Broadcast: clear on transfer, victim write when a fill token leaves the row without having taken an empty slot
    always_comb
    begin
        bcast.clear     = req_xfer && (req_op == tlc_pkg::OP_CLEAR);
        bcast.wr_en     = tok_end.live && (tok_end.op == tlc_pkg::OP_FILL)
                          && !tok_end.done;
        bcast.frame     = frame_reg;
        bcast.key_id    = tok_end.key_id;
        bcast.key_count = tok_end.key_count;
        bcast.handle    = tok_end.handle;
    end

    // Cell chain
    assign tok_w[0] = launch_reg;
    assign idx_w[0] = '0;

    for (genvar i = 0; i < ENTRIES; i++)
    begin : g_cell
        tlc_cell #(
            .IDX_W (IDX_W),
            .INDEX (i)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .tok_in  (tok_w[i]),
            .idx_in  (idx_w[i]),
            .tok_out (tok_w[i+1]),
            .idx_out (idx_w[i+1]),
            .bcast   (bcast),
            .wr_idx  (idx_end)
        );
    end

    // Control, token launch and result capture
    always_comb
    begin
        state_next     = state_reg;
        frame_next     = frame_reg;
        launch_next    = launch_reg;
        launch_next.live = 1'b0;
        res_hit_next   = res_hit_reg;
        res_found_next = res_found_reg;
        res_slot_next  = res_slot_reg;
        res_ev_next    = res_ev_reg;
        res_evh_next   = res_evh_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        hit_next       = hit_reg;
        found_next     = found_reg;
        slot_next      = slot_reg;
        ev_next        = ev_reg;
        evh_next       = evh_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_xfer)
                begin
                    if ((req_op == tlc_pkg::OP_LOOKUP) || (req_op == tlc_pkg::OP_FILL))
                    begin
                        launch_next.live        = 1'b1;
                        launch_next.op          = req_op;
                        launch_next.done        = 1'b0;
                        launch_next.sel_valid   = 1'b0;
                        launch_next.key_id      = key_id;
                        launch_next.key_count   = key_count;
                        launch_next.handle      = fill_handle;
                        launch_next.sel_payload = '0;
                        launch_next.best_age    = '0;
                        state_next              = ST_SCAN;
                    end
                    else
                    begin
                        if (req_op == tlc_pkg::OP_TICK)
                        begin
                            frame_next = frame_reg + 1'b1;
                        end
                        res_hit_next   = 1'b0;
                        res_found_next = '0;
                        res_slot_next  = '0;
                        res_ev_next    = 1'b0;
                        res_evh_next   = '0;
                        state_next     = ST_DELIVER;
                    end
                end
            end
            ST_SCAN:
            begin
                if (tok_end.live)
                begin
                    if (tok_end.op == tlc_pkg::OP_FILL)
                    begin
                        res_hit_next   = 1'b0;
                        res_found_next = '0;
                        res_slot_next  = end_slot;
                        res_ev_next    = tok_end.sel_valid;
                        res_evh_next   = tok_end.sel_valid ? tok_end.sel_payload : '0;
                    end
                    else
                    begin
                        res_hit_next   = tok_end.done;
                        res_found_next = tok_end.done ? tok_end.sel_payload : '0;
                        res_slot_next  = tok_end.done ? end_slot : '0;
                        res_ev_next    = 1'b0;
                        res_evh_next   = '0;
                    end
                    state_next = ST_DELIVER;
                end
            end
            ST_DELIVER:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_valid_next = 1'b1;
                    hit_next       = res_hit_reg;
                    found_next     = res_found_reg;
                    slot_next      = res_slot_reg;
                    ev_next        = res_ev_reg;
                    evh_next       = res_evh_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            frame_reg     <= '0;
            launch_reg    <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            frame_reg     <= frame_next;
            launch_reg    <= launch_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Result payload registers
    always_ff @(posedge clk)
    begin
        res_hit_reg   <= res_hit_next;
        res_found_reg <= res_found_next;
        res_slot_reg  <= res_slot_next;
        res_ev_reg    <= res_ev_next;
        res_evh_reg   <= res_evh_next;
        hit_reg       <= hit_next;
        found_reg     <= found_next;
        slot_reg      <= slot_next;
        ev_reg        <= ev_next;
        evh_reg       <= evh_next;
    end

    assign rsp_valid      = rsp_valid_reg;
    assign hit            = hit_reg;
    assign found_handle   = found_reg;
    assign slot_index     = slot_reg;
    assign evicted        = ev_reg;
    assign evicted_handle = evh_reg;

endmodule

[hw/rtl/tlc_cell.sv]
// One cache entry plus its stage of the search token chain.
`timescale 1ns / 1ps

module tlc_cell #(
    parameter int IDX_W = 8,
    parameter int INDEX = 0
) (
    input  logic                clk,
    input  logic                rst_n,
    input  tlc_pkg::token_t     tok_in,
    input  logic [IDX_W-1:0]    idx_in,
    output tlc_pkg::token_t     tok_out,
    output logic [IDX_W-1:0]    idx_out,
    input  tlc_pkg::bcast_t     bcast,
    input  logic [IDX_W-1:0]    wr_idx
);

    localparam logic [IDX_W-1:0] MY_IDX   = IDX_W'(INDEX);
    localparam bit               IS_FIRST = (INDEX == 0);

    logic                            valid_reg, valid_next;
    logic [tlc_pkg::AGE_W-1:0]       age_reg, age_next;
    logic [tlc_pkg::KEY_ID_W-1:0]    key_id_reg, key_id_next;
    logic [tlc_pkg::KEY_COUNT_W-1:0] key_count_reg, key_count_next;
    logic [tlc_pkg::HANDLE_W-1:0]    payload_reg, payload_next;
    tlc_pkg::token_t                 tok_reg, tok_next;
    logic [IDX_W-1:0]                idx_reg, idx_next;

    logic key_match;
    logic self_fill;
    logic touch;

    assign key_match = valid_reg && (key_id_reg == tok_in.key_id)
                       && (key_count_reg == tok_in.key_count);

    // Token update: first match on lookup; on fill, first empty cell from 1 up, else the oldest
    always_comb
    begin
        tok_next  = tok_in;
        idx_next  = idx_in;
        self_fill = 1'b0;
        touch     = 1'b0;
        if (tok_in.live && !tok_in.done)
        begin
            unique case (tok_in.op)
                tlc_pkg::OP_LOOKUP:
                begin
                    if (key_match)
                    begin
                        tok_next.done        = 1'b1;
                        tok_next.sel_valid   = 1'b1;
                        tok_next.sel_payload = payload_reg;
                        idx_next             = MY_IDX;
                        touch                = 1'b1;
                    end
                end
                tlc_pkg::OP_FILL:
                begin
                    if (!IS_FIRST && !valid_reg)
                    begin
                        // empty slot: take it right here
                        tok_next.done        = 1'b1;
                        tok_next.sel_valid   = 1'b0;
                        tok_next.sel_payload = '0;
                        idx_next             = MY_IDX;
                        self_fill            = 1'b1;
                    end
                    else if (IS_FIRST || (age_reg < tok_in.best_age))
                    begin
                        tok_next.best_age    = age_reg;
                        tok_next.sel_valid   = valid_reg;
                        tok_next.sel_payload = payload_reg;
                        idx_next             = MY_IDX;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Entry update
    always_comb
    begin
        valid_next     = valid_reg;
        age_next       = age_reg;
        key_id_next    = key_id_reg;
        key_count_next = key_count_reg;
        payload_next   = payload_reg;
        priority if (bcast.clear)
        begin
            valid_next = 1'b0;
            age_next   = '0;
        end
        else if (bcast.wr_en && (wr_idx == MY_IDX))
        begin
            valid_next     = 1'b1;
            age_next       = bcast.frame;
            key_id_next    = bcast.key_id;
            key_count_next = bcast.key_count;
            payload_next   = bcast.handle;
        end
        else if (self_fill)
        begin
            valid_next     = 1'b1;
            age_next       = bcast.frame;
            key_id_next    = tok_in.key_id;
            key_count_next = tok_in.key_count;
            payload_next   = tok_in.handle;
        end
        else if (touch)
        begin
            age_next = bcast.frame;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            age_reg   <= '0;
            tok_reg   <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            age_reg   <= age_next;
            tok_reg   <= tok_next;
            idx_reg   <= idx_next;
        end
    end

    // Key and payload storage, meaningful only while valid
    always_ff @(posedge clk)
    begin
        key_id_reg    <= key_id_next;
        key_count_reg <= key_count_next;
        payload_reg   <= payload_next;
    end

    assign tok_out = tok_reg;
    assign idx_out = idx_reg;

endmodule

[tb/tb.sv]
// Self-checking testbench for the timestamp LRU tag cache: directed table, then random traffic.
`timescale 1ns / 1ps

module tb;

    localparam int CACHE_ENTRIES = 256;
    localparam int LAT           = CACHE_ENTRIES + 3;
    localparam int RAND_ITEMS    = 1500;
    localparam int CLEAR_AT      = 1100;
    localparam int POOL_MAX      = 512;

    typedef struct packed {
        logic                            hit;
        logic [tlc_pkg::HANDLE_W-1:0]    found;
        logic [tlc_pkg::SLOT_W-1:0]      slot;
        logic                            ev;
        logic [tlc_pkg::HANDLE_W-1:0]    ev_handle;
    } rsp_t;

    typedef struct packed {
        logic [tlc_pkg::KEY_ID_W-1:0]    id;
        logic [tlc_pkg::KEY_COUNT_W-1:0] cnt;
    } key_t;

    typedef struct packed {
        tlc_pkg::op_t                    code;
        key_t                            key;
        logic [tlc_pkg::HANDLE_W-1:0]    handle;
        logic                            typed;
        rsp_t                            rsp;
    } dir_row_t;

    localparam rsp_t RSP_NONE = '0;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        req_valid = 1'b0;
    logic        req_stall;
    logic [1:0]  op = tlc_pkg::OP_LOOKUP;
    logic [15:0] key_id = '0;
    logic [30:0] key_count = '0;
    logic [31:0] fill_handle = '0;
    logic        rsp_valid;
    logic        rsp_stall = 1'b0;
    logic        hit;
    logic [31:0] found_handle;
    logic [7:0]  slot_index;
    logic        evicted;
    logic [31:0] evicted_handle;

    // Shadow copy of the cache contents
    logic                            tag_valid  [CACHE_ENTRIES];
    logic [tlc_pkg::KEY_ID_W-1:0]    tag_id     [CACHE_ENTRIES];
    logic [tlc_pkg::KEY_COUNT_W-1:0] tag_count  [CACHE_ENTRIES];
    logic [tlc_pkg::HANDLE_W-1:0]    tag_handle [CACHE_ENTRIES];
    logic [tlc_pkg::AGE_W-1:0]       tag_age    [CACHE_ENTRIES];
    logic [tlc_pkg::AGE_W-1:0]       frame_now;

    rsp_t     pending_rsp [$];
    key_t     key_pool [$];
    dir_row_t dir_tbl [$];
    int       fail_cnt = 0;
    int       stall_left = 0;

    timestamp_lru_tag_cache #(
        .ENTRIES (CACHE_ENTRIES)
    ) i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .req_valid      (req_valid),
        .req_stall      (req_stall),
        .op             (op),
        .key_id         (key_id),
        .key_count      (key_count),
        .fill_handle    (fill_handle),
        .rsp_valid      (rsp_valid),
        .rsp_stall      (rsp_stall),
        .hit            (hit),
        .found_handle   (found_handle),
        .slot_index     (slot_index),
        .evicted        (evicted),
        .evicted_handle (evicted_handle)
    );

    always #4 clk = ~clk;

    // Apply one request to the shadow cache and return the result it gives
    function automatic rsp_t cache_step(tlc_pkg::op_t code, key_t key,
                                        logic [tlc_pkg::HANDLE_W-1:0] handle);
        rsp_t                      r;
        int                        i;
        int                        victim;
        logic                      took_empty;
        logic [tlc_pkg::AGE_W-1:0] best_age;
        r = '0;
        case (code)
            tlc_pkg::OP_LOOKUP:
            begin
                // lowest matching valid entry wins
                for (i = 0; i < CACHE_ENTRIES; i++)
                begin
                    if (!r.hit && tag_valid[i] && tag_id[i] == key.id && tag_count[i] == key.cnt)
                    begin
                        tag_age[i] = frame_now;
                        r.hit   = 1'b1;
                        r.found = tag_handle[i];
                        r.slot  = i[tlc_pkg::SLOT_W-1:0];
                    end
                end
            end
            tlc_pkg::OP_FILL:
            begin
                // first empty slot from 1 up, else oldest age with slot 0 in the race
                victim     = 0;
                best_age   = tag_age[0];
                took_empty = 1'b0;
                for (i = 1; i < CACHE_ENTRIES; i++)
                begin
                    if (!took_empty)
                    begin
                        if (!tag_valid[i])
                        begin
                            victim     = i;
                            took_empty = 1'b1;
                        end
                        else if (tag_age[i] < best_age)
                        begin
                            best_age = tag_age[i];
                            victim   = i;
                        end
                    end
                end
                r.slot      = victim[tlc_pkg::SLOT_W-1:0];
                r.ev        = tag_valid[victim];
                r.ev_handle = tag_valid[victim] ? tag_handle[victim] : '0;
                tag_valid[victim]  = 1'b1;
                tag_id[victim]     = key.id;
                tag_count[victim]  = key.cnt;
                tag_handle[victim] = handle;
                tag_age[victim]    = frame_now;
            end
            tlc_pkg::OP_TICK:
                frame_now = frame_now + 1;
            default:
            begin
                for (i = 0; i < CACHE_ENTRIES; i++)
                begin
                    tag_valid[i] = 1'b0;
                    tag_age[i]   = '0;
                end
            end
        endcase
        return r;
    endfunction

    task automatic add_row(tlc_pkg::op_t code, logic [15:0] kid, logic [30:0] kcnt,
                           logic [31:0] handle, logic typed, rsp_t rsp);
        dir_row_t row;
        row.code    = code;
        row.key.id  = kid;
        row.key.cnt = kcnt;
        row.handle  = handle;
        row.typed   = typed;
        row.rsp     = rsp;
        dir_tbl.push_back(row);
    endtask

    // Drive one request, wait for its transfer, then record what it should return
    task automatic issue(tlc_pkg::op_t code, key_t key, logic [tlc_pkg::HANDLE_W-1:0] handle,
                         logic typed, rsp_t typed_rsp);
        rsp_t pred;
        op          <= code;
        key_id      <= key.id;
        key_count   <= key.cnt;
        fill_handle <= handle;
        req_valid   <= 1'b1;
        @(negedge clk);
        while (req_stall)
            @(negedge clk);
        @(posedge clk);
        pred = cache_step(code, key, handle);
        pending_rsp.push_back(typed ? typed_rsp : pred);
    endtask

    // Sender gap; with drain set it also holds off until every result is back
    task automatic idle_gap(int cycles, bit drain);
        req_valid <= 1'b0;
        repeat (cycles)
            @(posedge clk);
        while (drain && pending_rsp.size() != 0)
            @(posedge clk);
    endtask

    function automatic key_t rand_key();
        key_t k;
        k.id  = tlc_pkg::KEY_ID_W'($urandom());
        k.cnt = tlc_pkg::KEY_COUNT_W'($urandom());
        return k;
    endfunction

    // Result side: compare each transfer against the oldest expectation
    always @(negedge clk)
    begin : chk_rsp
        rsp_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (pending_rsp.size() == 0)
            begin
                $display("%0t: unexpected result transfer, got hit=%0d slot=%0d", $time,
                         hit, slot_index);
                fail_cnt++;
            end
            else
            begin
                want = pending_rsp.pop_front();
                if (hit !== want.hit)
                begin
                    $display("%0t: hit expected %0d got %0d", $time, want.hit, hit);
                    fail_cnt++;
                end
                if (found_handle !== want.found)
                begin
                    $display("%0t: found_handle expected %h got %h", $time, want.found,
                             found_handle);
                    fail_cnt++;
                end
                if (slot_index !== want.slot)
                begin
                    $display("%0t: slot_index expected %0d got %0d", $time, want.slot,
                             slot_index);
                    fail_cnt++;
                end
                if (evicted !== want.ev)
                begin
                    $display("%0t: evicted expected %0d got %0d", $time, want.ev, evicted);
                    fail_cnt++;
                end
                if (evicted_handle !== want.ev_handle)
                begin
                    $display("%0t: evicted_handle expected %h got %h", $time, want.ev_handle,
                             evicted_handle);
                    fail_cnt++;
                end
            end
        end
    end

    // Receiver back-pressure: segments of stall or free flow, free stretches sometimes long
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            rsp_stall  <= 1'b0;
            stall_left <= 0;
        end
        else if (stall_left == 0)
        begin
            if ($urandom_range(0, 2) == 0)
            begin
                rsp_stall  <= 1'b1;
                stall_left <= $urandom_range(1, 300);
            end
            else
            begin
                rsp_stall  <= 1'b0;
                stall_left <= ($urandom_range(0, 7) == 0) ? 3000 : $urandom_range(1, 300);
            end
        end
        else
            stall_left <= stall_left - 1;
    end

    // Stimulus
    initial
    begin : stim
        int                           i;
        int                           n;
        int                           sel;
        int                           burst_left;
        bit                           drain;
        tlc_pkg::op_t                 code;
        key_t                         key;
        logic [tlc_pkg::HANDLE_W-1:0] handle;

        for (i = 0; i < CACHE_ENTRIES; i++)
        begin
            tag_valid[i]  = 1'b0;
            tag_id[i]     = '0;
            tag_count[i]  = '0;
            tag_handle[i] = '0;
            tag_age[i]    = '0;
        end
        frame_now = '0;

        // Directed rows: empty cache, key extremes, handle zero, duplicates, tick, clear
        add_row(tlc_pkg::OP_LOOKUP, 16'h0000, 31'h00000000, 32'h00000000, 1'b1, RSP_NONE);
        add_row(tlc_pkg::OP_LOOKUP, 16'hFFFF, 31'h7FFFFFFF, 32'hFFFFFFFF, 1'b1, RSP_NONE);
        add_row(tlc_pkg::OP_FILL,   16'h0000, 31'h00000000, 32'hFFFFFFFF, 1'b1,
                {1'b0, 32'h0, 8'd1, 1'b0, 32'h0});
        add_row(tlc_pkg::OP_FILL,   16'hFFFF, 31'h7FFFFFFF, 32'h00000000, 1'b1,
                {1'b0, 32'h0, 8'd2, 1'b0, 32'h0});
        add_row(tlc_pkg::OP_LOOKUP, 16'h0000, 31'h00000000, 32'h00000000, 1'b1,
                {1'b1, 32'hFFFFFFFF, 8'd1, 1'b0, 32'h0});
        add_row(tlc_pkg::OP_LOOKUP, 16'hFFFF, 31'h7FFFFFFF, 32'h00000000, 1'b1,
                {1'b1, 32'h00000000, 8'd2, 1'b0, 32'h0});
        add_row(tlc_pkg::OP_LOOKUP, 16'hFFFF, 31'h00000000, 32'h00000000, 1'b1, RSP_NONE);
        add_row(tlc_pkg::OP_LOOKUP, 16'h0000, 31'h7FFFFFFF, 32'h00000000, 1'b1, RSP_NONE);
        add_row(tlc_pkg::OP_TICK,   16'hFFFF, 31'h7FFFFFFF, 32'hFFFFFFFF, 1'b1, RSP_NONE);
        add_row(tlc_pkg::OP_FILL,   16'h1234, 31'h00000005, 32'hA5A5A5A5, 1'b1,
                {1'b0, 32'h0, 8'd3, 1'b0, 32'h0});
        add_row(tlc_pkg::OP_FILL,   16'h1234, 31'h00000005, 32'h5A5A5A5A, 1'b1,
                {1'b0, 32'h0, 8'd4, 1'b0, 32'h0});
        add_row(tlc_pkg::OP_LOOKUP, 16'h1234, 31'h00000005, 32'h00000000, 1'b1,
                {1'b1, 32'hA5A5A5A5, 8'd3, 1'b0, 32'h0});
        add_row(tlc_pkg::OP_TICK,   16'h0000, 31'h00000000, 32'h00000000, 1'b1, RSP_NONE);
        add_row(tlc_pkg::OP_LOOKUP, 16'h0000, 31'h00000000, 32'h00000000, 1'b0, RSP_NONE);
        add_row(tlc_pkg::OP_FILL,   16'h0F0F, 31'h0F0F0F0F, 32'h0F0F0F0F, 1'b0, RSP_NONE);
        add_row(tlc_pkg::OP_CLEAR,  16'hFFFF, 31'h7FFFFFFF, 32'hFFFFFFFF, 1'b1, RSP_NONE);
        add_row(tlc_pkg::OP_LOOKUP, 16'h0000, 31'h00000000, 32'h00000000, 1'b1, RSP_NONE);
        add_row(tlc_pkg::OP_FILL,   16'hAAAA, 31'h55555555, 32'h12345678, 1'b1,
                {1'b0, 32'h0, 8'd1, 1'b0, 32'h0});
        add_row(tlc_pkg::OP_FILL,   16'h5555, 31'h2AAAAAAA, 32'h87654321, 1'b1,
                {1'b0, 32'h0, 8'd2, 1'b0, 32'h0});
        add_row(tlc_pkg::OP_LOOKUP, 16'h5555, 31'h2AAAAAAA, 32'h00000000, 1'b1,
                {1'b1, 32'h87654321, 8'd2, 1'b0, 32'h0});
        add_row(tlc_pkg::OP_TICK,   16'h0000, 31'h00000000, 32'h00000000, 1'b1, RSP_NONE);
        add_row(tlc_pkg::OP_CLEAR,  16'h0000, 31'h00000000, 32'h00000000, 1'b1, RSP_NONE);

        // Reset once
        repeat (10)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, back to back
        for (i = 0; i < dir_tbl.size(); i++)
            issue(dir_tbl[i].code, dir_tbl[i].key, dir_tbl[i].handle, dir_tbl[i].typed,
                  dir_tbl[i].rsp);

        // Random part: enough fills that the cache runs full and starts evicting
        burst_left = 0;
        for (n = 0; n < RAND_ITEMS; n++)
        begin
            drain = (n == 0) || (n == RAND_ITEMS / 2);
            if (burst_left == 0 || drain)
            begin
                if (burst_left == 0)
                    burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 40)
                                                             : $urandom_range(1, 6);
                idle_gap($urandom_range(1, 400), drain);
            end
            burst_left--;

            sel = $urandom_range(0, 999);
            if (n == CLEAR_AT || sel < 1)
                code = tlc_pkg::OP_CLEAR;
            else if (sel < 450)
                code = tlc_pkg::OP_LOOKUP;
            else if (sel < 880)
                code = tlc_pkg::OP_FILL;
            else
                code = tlc_pkg::OP_TICK;

            key    = rand_key();
            handle = $urandom();
            if (code == tlc_pkg::OP_LOOKUP && key_pool.size() != 0 && $urandom_range(0, 3) != 0)
            begin
                key = key_pool[$urandom_range(0, key_pool.size() - 1)];
                // same id, other count: near miss
                if ($urandom_range(0, 7) == 0)
                    key.cnt = tlc_pkg::KEY_COUNT_W'($urandom());
            end
            else if (code == tlc_pkg::OP_FILL)
            begin
                // occasional duplicate key
                if (key_pool.size() != 0 && $urandom_range(0, 9) == 0)
                    key = key_pool[$urandom_range(0, key_pool.size() - 1)];
                key_pool.push_back(key);
                if (key_pool.size() > POOL_MAX)
                    void'(key_pool.pop_front());
            end
            else if (code == tlc_pkg::OP_CLEAR)
                key_pool.delete();

            issue(code, key, handle, 1'b0, RSP_NONE);
        end

        // Let everything drain, then allow for any trailing work
        idle_gap(1, 1'b1);
        repeat (LAT + 8)
            @(posedge clk);
        if (fail_cnt == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Watchdog
    initial
    begin
        #(64'd50_000_000);
        $display("Test completed with failures");
        $finish;
    end

endmodule

[sim.f]
hw/rtl/tlc_pkg.sv
hw/rtl/tlc_cell.sv
hw/rtl/timestamp_lru_tag_cache.sv
tb/tb.sv
